>>> sv/lrt_pkg.sv
package lrt_pkg;

    localparam int MAX_FEATURES = 64;
    localparam int MAX_OUTPUTS  = 16;
    localparam int FRAC_BITS    = 16;
    localparam int RATE_BITS    = 16;

    localparam int FIDX_W = $clog2(MAX_FEATURES);
    localparam int HOP_W  = $clog2(MAX_OUTPUTS + 1);
    localparam int CIDX_W = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int ADDR_W = 4;

    // Cycles from the last token leaving the controller until every cell has settled.
    localparam int DRAIN_CYC = MAX_OUTPUTS + 6;
    localparam int WAIT_W    = $clog2(DRAIN_CYC + 1);

    localparam logic [1:0] REQ_WEIGHT  = 2'd0;
    localparam logic [1:0] REQ_BIAS    = 2'd1;
    localparam logic [1:0] REQ_FEATURE = 2'd2;
    localparam logic [1:0] REQ_TARGET  = 2'd3;

    localparam logic [1:0] ST_PREDICT = 2'd0;
    localparam logic [1:0] ST_ERROR   = 2'd1;
    localparam logic [1:0] ST_REJECT  = 2'd2;

    localparam logic [1:0] REG_INPUT_COUNT   = 2'd0;
    localparam logic [1:0] REG_OUTPUT_COUNT  = 2'd1;
    localparam logic [1:0] REG_LEARNING_RATE = 2'd2;

    typedef enum logic [1:0] {
        TK_PRED,
        TK_UPD,
        TK_WGT,
        TK_BIAS
    } tok_kind_t;

    typedef struct packed {
        logic                vld;
        tok_kind_t           kind;
        logic                first;
        logic [FIDX_W-1:0]   idx;
        logic [HOP_W-1:0]    col;
        logic [HOP_W-1:0]    hop;
        logic signed [31:0]  data;
    } tok_t;

    typedef struct packed {
        logic                en;
        logic [FIDX_W-1:0]   addr;
    } clr_t;

    typedef struct packed {
        logic [6:0]  input_count;
        logic [4:0]  output_count;
        logic [15:0] learning_rate;
        logic        ic_wr;
    } cfg_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_ERR,
        S_MUL,
        S_RND,
        S_EMIT
    } state_t;

    function automatic logic signed [63:0] sat64(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sh0_7FFF_FFFF_FFFF_FFFF;
        lo = -hi - 66'sd1;
        if (v > hi)
            sat64 = hi[63:0];
        else if (v < lo)
            sat64 = lo[63:0];
        else
            sat64 = v[63:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            sat32 = 32'sh7FFF_FFFF;
        else if (v < -66'sd2147483648)
            sat32 = 32'sh8000_0000;
        else
            sat32 = v[31:0];
    endfunction

endpackage

>>> sv/lrt_req_if.sv
interface lrt_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [5:0]         row_index;
    logic [3:0]         col_index;
    logic signed [31:0] data_value;
    logic               last_feature;

    modport source (output valid, req_type, row_index, col_index, data_value, last_feature,
                    input ready);
    modport sink (input valid, req_type, row_index, col_index, data_value, last_feature,
                  output ready);
endinterface

>>> sv/lrt_res_if.sv
interface lrt_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [3:0]         out_column;
    logic signed [31:0] result_value;
    logic               last_result;

    modport source (output valid, status, out_column, result_value, last_result,
                    input ready);
    modport sink (input valid, status, out_column, result_value, last_result,
                  output ready);
endinterface

>>> sv/linear_regressor_lms_trainer_unit.sv
// Linear regressor with online delta-rule training.
// The req channel carries weight writes, bias writes, feature items and training
// targets; the res channel returns predictions, training errors and rejects. The
// block takes one item at a time: req.ready is high only while it is idle.
// Each output column is a cell in a chain that holds that column's weights and bias;
// feature tokens enter the first cell and move one cell per clock, so each cell runs
// its own multiply-accumulate in the cycle after its neighbor.
// A weight or bias write is followed by a chain drain before the next item is taken. A
// last feature item completing the vector starts a prediction pass; once it has drained,
// predictions leave one per cycle while the receiver is ready. A target takes two passes
// through the chain (one for the prediction, one for the weight update) plus the error
// and delta steps.
// After reset the weight memories are cleared, one row per cycle; no item is taken
// meanwhile, configuration writes are. A stalled receiver holds the result in the
// output register; the next item is still taken, and any result it causes waits
// until the output register is free.
module linear_regressor_lms_trainer_unit
    import lrt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    lrt_req_if.sink           req,
    lrt_res_if.source         res
);

    logic [6:0]  ic_reg;
    logic [4:0]  oc_reg;
    logic [15:0] lr_reg;
    logic        wr;
    cfg_t        cfg;

    tok_t                          chain [MAX_OUTPUTS+1];
    logic [MAX_OUTPUTS-1:0][63:0]  acc;
    logic signed [32:0]            delta;
    clr_t                          clr;

    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ic_reg <= 7'd1;
            oc_reg <= 5'd1;
            lr_reg <= 16'd655;
        end
        else if (wr)
        begin
            case (paddr[3:2])
                REG_INPUT_COUNT:   ic_reg <= pwdata[6:0];
                REG_OUTPUT_COUNT:  oc_reg <= pwdata[4:0];
                REG_LEARNING_RATE: lr_reg <= pwdata[15:0];
                default:           ic_reg <= ic_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_INPUT_COUNT:   prdata = {25'd0, ic_reg};
            REG_OUTPUT_COUNT:  prdata = {27'd0, oc_reg};
            REG_LEARNING_RATE: prdata = {16'd0, lr_reg};
            default:           prdata = '0;
        endcase
    end

    assign cfg.input_count   = ic_reg;
    assign cfg.output_count  = oc_reg;
    assign cfg.learning_rate = lr_reg;
    assign cfg.ic_wr         = wr && (paddr[3:2] == REG_INPUT_COUNT);

    lrt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res),
        .cfg   (cfg),
        .acc   (acc),
        .tok   (chain[0]),
        .delta (delta),
        .clr   (clr)
    );

    for (genvar k = 0; k < MAX_OUTPUTS; k++)
    begin : g_cell
        lrt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (chain[k]),
            .tok_out (chain[k+1]),
            .delta   (delta),
            .clr     (clr),
            .acc     (acc[k])
        );
    end

endmodule

>>> sv/lrt_cell.sv
module lrt_cell
    import lrt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  tok_t               tok_in,
    output tok_t               tok_out,
    input  logic signed [32:0] delta,
    input  clr_t               clr,
    output logic signed [63:0] acc
);

    logic signed [31:0] mem [MAX_FEATURES];

    tok_t               tok_out_reg;
    tok_t               tok_out_next;
    tok_t               b_tok_reg;
    tok_t               c_tok_reg;
    logic signed [31:0] rd_reg;
    logic signed [31:0] c_w_reg;
    logic signed [64:0] prod_reg;
    logic signed [64:0] prod_next;
    logic signed [63:0] acc_reg;
    logic signed [63:0] acc_next;
    logic signed [31:0] bias_reg;
    logic signed [31:0] bias_next;
    logic signed [32:0] mul_a;
    logic signed [65:0] rnd;
    logic               c_match;
    logic               we;
    logic signed [31:0] wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_out_reg <= '0;
            b_tok_reg   <= '0;
            c_tok_reg   <= '0;
            bias_reg    <= '0;
        end
        else
        begin
            tok_out_reg <= tok_out_next;
            b_tok_reg   <= tok_in;
            c_tok_reg   <= b_tok_reg;
            bias_reg    <= bias_next;
        end
    end

    always_comb
    begin
        tok_out_next     = tok_in;
        tok_out_next.hop = tok_in.hop + HOP_W'(1);
    end

    always_ff @(posedge clk)
    begin
        rd_reg   <= mem[tok_in.idx];
        c_w_reg  <= rd_reg;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (clr.en)
            mem[clr.addr] <= '0;
        else if (we)
            mem[c_tok_reg.idx] <= wdata;
    end

    // The update pass scales each feature by the shared delta; prediction scales it by
    // the stored weight.
    always_comb
    begin
        mul_a     = (b_tok_reg.kind == TK_UPD) ? delta : 33'(rd_reg);
        prod_next = mul_a * b_tok_reg.data;
    end

    always_comb
    begin
        rnd       = (66'(prod_reg) + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        c_match   = (c_tok_reg.hop == c_tok_reg.col);
        acc_next  = acc_reg;
        bias_next = bias_reg;
        we        = 1'b0;
        wdata     = c_tok_reg.data;
        if (c_tok_reg.vld)
        begin
            case (c_tok_reg.kind)
                TK_PRED:
                begin
                    if (c_tok_reg.first)
                        acc_next = sat64(66'(bias_reg) + rnd);
                    else
                        acc_next = sat64(66'(acc_reg) + rnd);
                end
                TK_UPD:
                begin
                    if (c_match)
                    begin
                        we    = 1'b1;
                        wdata = sat32(66'(c_w_reg) + rnd);
                        if (c_tok_reg.first)
                            bias_next = sat32(66'(bias_reg) + 66'(delta));
                    end
                end
                TK_WGT:
                begin
                    we = c_match;
                end
                TK_BIAS:
                begin
                    if (c_match)
                        bias_next = c_tok_reg.data;
                end
                default:
                begin
                    we = 1'b0;
                end
            endcase
        end
    end

    assign tok_out = tok_out_reg;
    assign acc     = acc_reg;

endmodule

>>> sv/lrt_ctrl.sv
module lrt_ctrl
    import lrt_pkg::*;
(
    input  logic                               clk,
    input  logic                               rst_n,
    lrt_req_if.sink                            req,
    lrt_res_if.source                          res,
    input  cfg_t                               cfg,
    input  logic [MAX_OUTPUTS-1:0][63:0]       acc,
    output tok_t                               tok,
    output logic signed [32:0]                 delta,
    output clr_t                               clr
);

    logic signed [31:0] fb_mem [MAX_FEATURES];
    logic [MAX_FEATURES-1:0] fb_vld_reg, fb_vld_next;
    logic signed [31:0] fb_rd_reg;
    logic               fb_rv_reg;
    logic               fb_we;
    logic [FIDX_W-1:0]  fb_waddr;

    state_t             state_reg, state_next;
    logic [FIDX_W-1:0]  cnt_reg, cnt_next;
    logic [WAIT_W-1:0]  wait_reg, wait_next;
    tok_kind_t          pass_reg, pass_next;
    logic               tgt_reg, tgt_next;
    logic [6:0]         fcount_reg, fcount_next;
    logic               vready_reg, vready_next;
    logic [HOP_W-1:0]   j_reg, j_next;
    logic [HOP_W-1:0]   tcol_reg, tcol_next;
    logic signed [31:0] target_reg, target_next;
    logic signed [31:0] err_reg, err_next;
    logic signed [48:0] lrprod_reg, lrprod_next;
    logic signed [32:0] delta_reg, delta_next;

    logic               iss_vld_reg, iss_vld_next;
    tok_kind_t          iss_kind_reg, iss_kind_next;
    logic               iss_first_reg, iss_first_next;
    logic [FIDX_W-1:0]  iss_idx_reg, iss_idx_next;
    logic [HOP_W-1:0]   iss_col_reg, iss_col_next;
    logic signed [31:0] iss_data_reg, iss_data_next;
    logic               iss_usefb_reg, iss_usefb_next;

    logic               out_vld_reg, out_vld_next;
    logic [1:0]         out_st_reg, out_st_next;
    logic [3:0]         out_col_reg, out_col_next;
    logic signed [31:0] out_val_reg, out_val_next;
    logic               out_last_reg, out_last_next;

    logic               take;
    logic               out_free;
    logic               geom_ok;
    logic [6:0]         fc_inc;
    logic signed [63:0] acc_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            wait_reg    <= '0;
            pass_reg    <= TK_PRED;
            tgt_reg     <= 1'b0;
            fcount_reg  <= '0;
            vready_reg  <= 1'b0;
            fb_vld_reg  <= '0;
            iss_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            wait_reg    <= wait_next;
            pass_reg    <= pass_next;
            tgt_reg     <= tgt_next;
            fcount_reg  <= fcount_next;
            vready_reg  <= cfg.ic_wr ? 1'b0 : vready_next;
            fb_vld_reg  <= fb_vld_next;
            iss_vld_reg <= iss_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg         <= j_next;
        tcol_reg      <= tcol_next;
        target_reg    <= target_next;
        err_reg       <= err_next;
        lrprod_reg    <= lrprod_next;
        delta_reg     <= delta_next;
        iss_kind_reg  <= iss_kind_next;
        iss_first_reg <= iss_first_next;
        iss_idx_reg   <= iss_idx_next;
        iss_col_reg   <= iss_col_next;
        iss_data_reg  <= iss_data_next;
        iss_usefb_reg <= iss_usefb_next;
        out_st_reg    <= out_st_next;
        out_col_reg   <= out_col_next;
        out_val_reg   <= out_val_next;
        out_last_reg  <= out_last_next;
        fb_rd_reg     <= fb_mem[cnt_reg];
        fb_rv_reg     <= fb_vld_reg[cnt_reg];
        if (fb_we)
            fb_mem[fb_waddr] <= req.data_value;
    end

    assign take     = res.valid && res.ready;
    assign out_free = !out_vld_reg || res.ready;
    assign geom_ok  = (cfg.input_count >= 7'd1) && (32'(cfg.input_count) <= MAX_FEATURES) &&
                      (cfg.output_count >= 5'd1) && (32'(cfg.output_count) <= MAX_OUTPUTS);
    assign fc_inc   = (fcount_reg == 7'd127) ? fcount_reg : fcount_reg + 7'd1;
    assign acc_sel  = signed'(acc[j_reg[CIDX_W-1:0]]);
    assign fb_waddr = FIDX_W'(req.row_index);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        wait_next      = wait_reg;
        pass_next      = pass_reg;
        tgt_next       = tgt_reg;
        fcount_next    = fcount_reg;
        vready_next    = vready_reg;
        fb_vld_next    = fb_vld_reg;
        j_next         = j_reg;
        tcol_next      = tcol_reg;
        target_next    = target_reg;
        err_next       = err_reg;
        lrprod_next    = lrprod_reg;
        delta_next     = delta_reg;
        iss_vld_next   = 1'b0;
        iss_kind_next  = iss_kind_reg;
        iss_first_next = 1'b0;
        iss_idx_next   = iss_idx_reg;
        iss_col_next   = iss_col_reg;
        iss_data_next  = iss_data_reg;
        iss_usefb_next = iss_usefb_reg;
        out_vld_next   = take ? 1'b0 : out_vld_reg;
        out_st_next    = out_st_reg;
        out_col_next   = out_col_reg;
        out_val_next   = out_val_reg;
        out_last_next  = out_last_reg;
        fb_we          = 1'b0;
        clr.en         = 1'b0;
        clr.addr       = cnt_reg;

        case (state_reg)
            S_CLEAR:
            begin
                clr.en   = 1'b1;
                cnt_next = cnt_reg + FIDX_W'(1);
                if (32'(cnt_reg) == MAX_FEATURES - 1)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.req_type)
                        REQ_WEIGHT, REQ_BIAS:
                        begin
                            if ((32'(req.row_index) < MAX_FEATURES || req.req_type == REQ_BIAS) &&
                                32'(req.col_index) < MAX_OUTPUTS)
                            begin
                                iss_vld_next = 1'b1;
                            end
                            iss_kind_next  = (req.req_type == REQ_BIAS) ? TK_BIAS : TK_WGT;
                            iss_idx_next   = FIDX_W'(req.row_index);
                            iss_col_next   = HOP_W'(req.col_index);
                            iss_data_next  = req.data_value;
                            iss_usefb_next = 1'b0;
                            pass_next      = TK_WGT;
                            wait_next      = WAIT_W'(DRAIN_CYC);
                            state_next     = S_DRAIN;
                        end
                        REQ_FEATURE:
                        begin
                            if (32'(req.row_index) < MAX_FEATURES)
                            begin
                                fb_we                 = 1'b1;
                                fb_vld_next[fb_waddr] = 1'b1;
                            end
                            fcount_next = fc_inc;
                            vready_next = 1'b0;
                            if (req.last_feature)
                            begin
                                fcount_next = '0;
                                if (geom_ok && fc_inc == cfg.input_count)
                                begin
                                    vready_next = 1'b1;
                                    pass_next   = TK_PRED;
                                    tgt_next    = 1'b0;
                                    cnt_next    = '0;
                                    state_next  = S_ISSUE;
                                end
                                else
                                begin
                                    state_next = S_EMIT;
                                    pass_next  = TK_BIAS;
                                end
                            end
                        end
                        default:
                        begin
                            if (!vready_reg || !geom_ok ||
                                5'(req.col_index) >= cfg.output_count)
                            begin
                                state_next = S_EMIT;
                                pass_next  = TK_BIAS;
                            end
                            else
                            begin
                                target_next = req.data_value;
                                tcol_next   = HOP_W'(req.col_index);
                                pass_next   = TK_PRED;
                                tgt_next    = 1'b1;
                                cnt_next    = '0;
                                state_next  = S_ISSUE;
                            end
                        end
                    endcase
                end
            end
            S_ISSUE:
            begin
                iss_vld_next   = 1'b1;
                iss_kind_next  = pass_reg;
                iss_first_next = (cnt_reg == '0);
                iss_idx_next   = cnt_reg;
                iss_col_next   = tcol_reg;
                iss_usefb_next = 1'b1;
                cnt_next       = cnt_reg + FIDX_W'(1);
                if (cnt_reg == FIDX_W'(cfg.input_count - 7'd1))
                begin
                    cnt_next   = '0;
                    wait_next  = WAIT_W'(DRAIN_CYC);
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                wait_next = wait_reg - WAIT_W'(1);
                if (wait_reg == '0)
                begin
                    j_next = '0;
                    case (pass_reg)
                        TK_PRED:
                            state_next = tgt_reg ? S_ERR : S_EMIT;
                        TK_UPD:
                            state_next = S_EMIT;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_ERR:
            begin
                j_next     = tcol_reg;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                err_next   = sat32(66'(target_reg) - 66'(sat32(66'(acc_sel))));
                state_next = S_RND;
            end
            S_RND:
            begin
                lrprod_next = signed'({1'b0, cfg.learning_rate}) * err_reg;
                state_next  = S_ISSUE;
                pass_next   = TK_UPD;
                cnt_next    = '0;
            end
            S_EMIT:
            begin
                // Predictions walk the cells one column per item; an error or a reject is
                // a single item. The fields are only loaded once the output register is free.
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_last_next = 1'b1;
                    case (pass_reg)
                        TK_PRED:
                        begin
                            out_st_next   = ST_PREDICT;
                            out_col_next  = 4'(j_reg);
                            out_val_next  = sat32(66'(acc_sel));
                            out_last_next = (5'(j_reg) == cfg.output_count - 5'd1);
                            j_next        = j_reg + HOP_W'(1);
                            if (5'(j_reg) == cfg.output_count - 5'd1)
                                state_next = S_IDLE;
                        end
                        TK_UPD:
                        begin
                            out_st_next  = ST_ERROR;
                            out_col_next = 4'(tcol_reg);
                            out_val_next = err_reg;
                            state_next   = S_IDLE;
                        end
                        default:
                        begin
                            out_st_next  = ST_REJECT;
                            out_col_next = '0;
                            out_val_next = '0;
                            state_next   = S_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // The product is registered in the cycle before the update pass starts.
        delta_next = 33'((66'(lrprod_reg) + (66'sd1 <<< (RATE_BITS - 1))) >>> RATE_BITS);
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign res.valid      = out_vld_reg;
    assign res.status     = out_st_reg;
    assign res.out_column = out_col_reg;
    assign res.result_value = out_val_reg;
    assign res.last_result  = out_last_reg;

    assign tok.vld   = iss_vld_reg;
    assign tok.kind  = iss_kind_reg;
    assign tok.first = iss_first_reg;
    assign tok.idx   = iss_idx_reg;
    assign tok.col   = iss_col_reg;
    assign tok.hop   = '0;
    assign tok.data  = iss_usefb_reg ? (fb_rv_reg ? fb_rd_reg : 32'sd0) : iss_data_reg;
    assign delta     = delta_reg;

endmodule
